// ----- rtl/core/todc_pkg.sv -----
// ----------------------------------------------------------------------------
// todc_pkg
// Shared types, constants and wrap arithmetic for the time-of-day clock core.
// ----------------------------------------------------------------------------
`default_nettype none

package todc_pkg;

    typedef enum logic [2:0] {
        CMD_SET_CHECKED = 3'd0,
        CMD_SET_NORM    = 3'd1,
        CMD_INC         = 3'd2,
        CMD_DEC         = 3'd3,
        CMD_ADD         = 3'd4,
        CMD_SUB         = 3'd5,
        CMD_NEGATE      = 3'd6,
        CMD_DIFF        = 3'd7
    } cmd_t;

    localparam int STAGES        = 10;
    localparam int STATE_STAGE   = 8;

    localparam int MAX_HOUR      = 23;
    localparam int MAX_MIN_SEC   = 59;
    localparam int HOURS_PER_DAY = 24;
    localparam int MIN_SEC_RADIX = 60;
    localparam int HOUR_SECONDS  = 3600;

    // 86400 = 2^7 * 675: reduce the upper part modulo 675, keep the low 7 bits
    localparam int              DAY_LOW_BITS     = 7;
    localparam logic [9:0]      DAY_ODD          = 10'd675;
    localparam logic [31:0]     DAY_ODD_BIAS     = 32'd16777800;
    localparam logic [26:0]     RECIP_ODD        = 27'd101806633;
    localparam int              RECIP_ODD_SHIFT  = 36;
    localparam logic [13:0]     RECIP_HOUR       = 14'd9321;
    localparam int              RECIP_HOUR_SHIFT = 21;
    localparam logic [10:0]     RECIP_MIN        = 11'd1093;
    localparam int              RECIP_MIN_SHIFT  = 14;

    typedef struct packed {
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
    } hms_t;

    typedef struct packed {
        hms_t t;
        logic borrow;
    } hms_diff_t;

    function automatic hms_t hms_add(input hms_t a, input hms_t b);
        logic [6:0] s_sum;
        logic [6:0] m_sum;
        logic [5:0] h_sum;
        logic       cy_s;
        logic       cy_m;
        hms_t       r;
        s_sum = {1'b0, a.s} + {1'b0, b.s};
        cy_s  = (s_sum >= 7'(MIN_SEC_RADIX));
        r.s   = cy_s ? 6'(s_sum - 7'(MIN_SEC_RADIX)) : s_sum[5:0];
        m_sum = {1'b0, a.m} + {1'b0, b.m} + {6'd0, cy_s};
        cy_m  = (m_sum >= 7'(MIN_SEC_RADIX));
        r.m   = cy_m ? 6'(m_sum - 7'(MIN_SEC_RADIX)) : m_sum[5:0];
        h_sum = {1'b0, a.h} + {1'b0, b.h} + {5'd0, cy_m};
        r.h   = (h_sum >= 6'(HOURS_PER_DAY)) ? 5'(h_sum - 6'(HOURS_PER_DAY)) : h_sum[4:0];
        return r;
    endfunction

    // a - b field by field; hours stay raw modulo 32 with the final borrow
    function automatic hms_diff_t hms_sub(input hms_t a, input hms_t b);
        logic [6:0] s_dif;
        logic [6:0] m_dif;
        logic [5:0] h_dif;
        hms_diff_t  r;
        s_dif    = {1'b0, a.s} - {1'b0, b.s};
        r.t.s    = s_dif[6] ? 6'(s_dif + 7'(MIN_SEC_RADIX)) : s_dif[5:0];
        m_dif    = {1'b0, a.m} - {1'b0, b.m} - {6'd0, s_dif[6]};
        r.t.m    = m_dif[6] ? 6'(m_dif + 7'(MIN_SEC_RADIX)) : m_dif[5:0];
        h_dif    = {1'b0, a.h} - {1'b0, b.h} - {5'd0, m_dif[6]};
        r.t.h    = h_dif[4:0];
        r.borrow = h_dif[5];
        return r;
    endfunction

    function automatic hms_t hms_wrap(input hms_diff_t d);
        hms_t r;
        r   = d.t;
        r.h = d.borrow ? 5'(d.t.h + 5'(HOURS_PER_DAY)) : d.t.h;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/time_of_day_clock_arith_core.sv -----
// ----------------------------------------------------------------------------
// time_of_day_clock_arith_core
// 24-hour hh:mm:ss clock with set, step, offset, negate and difference beats.
//
//   channel | dir | tdata                                  | tuser
//   s_      | in  | hours, minutes, seconds, offset        | command
//   m_      | out | hours, minutes, seconds, difference    | invalid_time
//
// One beat per cycle sustained while the m_ side accepts results; a result
// passes through the ten-stage pipeline (input register, operand reduction and
// split, time update, result register).
// Only the time-update stage reads and writes the stored time.
// Reset clears the time to 00:00:00 and empties the pipeline.
// A stalled m_ side holds its beat; earlier stages keep filling bubbles, and
// s_tready drops once every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_clock_arith_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // hours_in, minutes_in, seconds_in, offset_seconds
    input  wire logic [2:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // hours_out, minutes_out, seconds_out, difference, zeros
    output logic             m_tuser    // invalid_time
);

    localparam int N = todc_pkg::STAGES;
    localparam int ST = todc_pkg::STATE_STAGE;

    logic [N-1:0] vld_reg;
    logic [N-1:0] adv;

    // stage 0: input beat
    todc_pkg::cmd_t     s0_cmd_reg;
    logic signed [15:0] s0_h_reg;
    logic signed [15:0] s0_m_reg;
    logic signed [15:0] s0_s_reg;
    logic signed [31:0] s0_off_reg;

    // stage 1: biased operand
    todc_pkg::cmd_t s1_cmd_reg;
    logic           s1_ok_reg;
    logic [25:0]    s1_y_reg;
    logic [6:0]     s1_lo_reg;

    // stage 2: quotient by 675
    todc_pkg::cmd_t s2_cmd_reg;
    logic           s2_ok_reg;
    logic [25:0]    s2_y_reg;
    logic [6:0]     s2_lo_reg;
    logic [15:0]    s2_q_reg;

    // stage 3: seconds of day
    todc_pkg::cmd_t s3_cmd_reg;
    logic           s3_ok_reg;
    logic [16:0]    s3_r_reg;

    // stage 4: hours
    todc_pkg::cmd_t s4_cmd_reg;
    logic           s4_ok_reg;
    logic [16:0]    s4_r_reg;
    logic [4:0]     s4_h_reg;

    // stage 5: seconds within hour
    todc_pkg::cmd_t s5_cmd_reg;
    logic           s5_ok_reg;
    logic [4:0]     s5_h_reg;
    logic [11:0]    s5_rem_reg;

    // stage 6: minutes
    todc_pkg::cmd_t s6_cmd_reg;
    logic           s6_ok_reg;
    logic [4:0]     s6_h_reg;
    logic [11:0]    s6_rem_reg;
    logic [5:0]     s6_m_reg;

    // stage 7: operand as hh:mm:ss
    todc_pkg::cmd_t   s7_cmd_reg;
    logic             s7_ok_reg;
    todc_pkg::hms_t   s7_op_reg;

    // stage 8: time update
    todc_pkg::hms_t cur_time_reg;
    todc_pkg::hms_t cur_time_next;
    todc_pkg::hms_t s8_show_reg;
    todc_pkg::hms_t s8_show_next;
    todc_pkg::hms_t s8_dif_reg;
    todc_pkg::hms_t s8_dif_next;
    logic           s8_bad_reg;
    logic           s8_bad_next;

    // stage 9: result beat
    todc_pkg::hms_t s9_show_reg;
    logic [16:0]    s9_dif_reg;
    logic           s9_bad_reg;

    logic signed [31:0] h_ext;
    logic signed [31:0] m_ext;
    logic signed [31:0] s_ext;
    logic signed [31:0] opnd;
    logic signed [31:0] sel_x;
    logic signed [31:0] sel_hi;
    logic [31:0]        y_sum;
    logic               set_ok;
    logic [52:0]        q_prod;
    logic [25:0]        q_mul;
    logic [25:0]        r_odd;
    logic [26:0]        h_prod;
    logic [16:0]        h_sec;
    logic [16:0]        rem_full;
    logic [20:0]        m_prod;
    logic [11:0]        m_sec;
    logic [11:0]        s_full;
    todc_pkg::hms_diff_t d_fwd;
    todc_pkg::hms_diff_t d_rev;
    todc_pkg::hms_diff_t d_neg;
    logic [16:0]        dif_sec;

    // ---------------- flow control ----------------
    always_comb
    begin
        adv[N-1] = !vld_reg[N-1] || m_tready;
        for (int i = N - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = {6'd0, s9_dif_reg, s9_show_reg.s, s9_show_reg.m, s9_show_reg.h};
    assign m_tuser  = s9_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            cur_time_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (adv[ST] && vld_reg[ST-1])
            begin
                cur_time_reg <= cur_time_next;
            end
        end
    end

    // ---------------- stage 1 logic ----------------
    always_comb
    begin
        h_ext  = {{16{s0_h_reg[15]}}, s0_h_reg};
        m_ext  = {{16{s0_m_reg[15]}}, s0_m_reg};
        s_ext  = {{16{s0_s_reg[15]}}, s0_s_reg};
        opnd   = (h_ext <<< 12) - (h_ext <<< 9) + (h_ext <<< 4)
               + (m_ext <<< 6) - (m_ext <<< 2) + s_ext;
        set_ok = !s0_h_reg[15] && (s0_h_reg[14:0] <= 15'(todc_pkg::MAX_HOUR))
              && !s0_m_reg[15] && (s0_m_reg[14:0] <= 15'(todc_pkg::MAX_MIN_SEC))
              && !s0_s_reg[15] && (s0_s_reg[14:0] <= 15'(todc_pkg::MAX_MIN_SEC));
        case (s0_cmd_reg) inside
            todc_pkg::CMD_ADD, todc_pkg::CMD_SUB: sel_x = s0_off_reg;
            todc_pkg::CMD_INC, todc_pkg::CMD_DEC: sel_x = 32'sd1;
            todc_pkg::CMD_NEGATE:                 sel_x = 32'sd0;
            default:                              sel_x = opnd;
        endcase
        sel_hi = sel_x >>> todc_pkg::DAY_LOW_BITS;
        y_sum  = 32'(sel_hi) + todc_pkg::DAY_ODD_BIAS;
    end

    // ---------------- stages 2 to 7 logic ----------------
    always_comb
    begin
        q_prod   = {27'd0, s1_y_reg} * {26'd0, todc_pkg::RECIP_ODD};
        q_mul    = {10'd0, s2_q_reg} * {16'd0, todc_pkg::DAY_ODD};
        r_odd    = s2_y_reg - q_mul;
        h_prod   = {14'd0, s3_r_reg[16:4]} * {13'd0, todc_pkg::RECIP_HOUR};
        h_sec    = {12'd0, s4_h_reg} * 17'(todc_pkg::HOUR_SECONDS);
        rem_full = s4_r_reg - h_sec;
        m_prod   = {11'd0, s5_rem_reg[11:2]} * {10'd0, todc_pkg::RECIP_MIN};
        m_sec    = {6'd0, s6_m_reg} * 12'(todc_pkg::MIN_SEC_RADIX);
        s_full   = s6_rem_reg - m_sec;
    end

    // ---------------- stage 8 logic: time update ----------------
    always_comb
    begin
        d_fwd         = todc_pkg::hms_sub(cur_time_reg, s7_op_reg);
        d_rev         = todc_pkg::hms_sub(s7_op_reg, cur_time_reg);
        d_neg         = todc_pkg::hms_sub('0, cur_time_reg);
        cur_time_next = cur_time_reg;
        s8_dif_next   = '0;
        s8_bad_next   = 1'b0;
        case (s7_cmd_reg) inside
            todc_pkg::CMD_SET_CHECKED:
            begin
                if (s7_ok_reg)
                begin
                    cur_time_next = s7_op_reg;
                end
                else
                begin
                    s8_bad_next = 1'b1;
                end
            end
            todc_pkg::CMD_SET_NORM:
            begin
                cur_time_next = s7_op_reg;
            end
            todc_pkg::CMD_INC, todc_pkg::CMD_ADD:
            begin
                cur_time_next = todc_pkg::hms_add(cur_time_reg, s7_op_reg);
            end
            todc_pkg::CMD_DEC, todc_pkg::CMD_SUB:
            begin
                cur_time_next = todc_pkg::hms_wrap(d_fwd);
            end
            todc_pkg::CMD_DIFF:
            begin
                s8_dif_next = d_fwd.borrow ? d_rev.t : d_fwd.t;
            end
            default:
            begin
                cur_time_next = cur_time_reg;
            end
        endcase
        s8_show_next = (s7_cmd_reg == todc_pkg::CMD_NEGATE) ? todc_pkg::hms_wrap(d_neg)
                                                            : cur_time_next;
        dif_sec      = {12'd0, s8_dif_reg.h} * 17'(todc_pkg::HOUR_SECONDS)
                     + {11'd0, s8_dif_reg.m} * 17'(todc_pkg::MIN_SEC_RADIX)
                     + {11'd0, s8_dif_reg.s};
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_cmd_reg <= todc_pkg::cmd_t'(s_tuser);
            s0_h_reg   <= s_tdata[15:0];
            s0_m_reg   <= s_tdata[31:16];
            s0_s_reg   <= s_tdata[47:32];
            s0_off_reg <= s_tdata[79:48];
        end
        if (adv[1])
        begin
            s1_cmd_reg <= s0_cmd_reg;
            s1_ok_reg  <= set_ok;
            s1_y_reg   <= y_sum[25:0];
            s1_lo_reg  <= sel_x[6:0];
        end
        if (adv[2])
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_ok_reg  <= s1_ok_reg;
            s2_y_reg   <= s1_y_reg;
            s2_lo_reg  <= s1_lo_reg;
            s2_q_reg   <= q_prod[todc_pkg::RECIP_ODD_SHIFT +: 16];
        end
        if (adv[3])
        begin
            s3_cmd_reg <= s2_cmd_reg;
            s3_ok_reg  <= s2_ok_reg;
            s3_r_reg   <= {r_odd[9:0], s2_lo_reg};
        end
        if (adv[4])
        begin
            s4_cmd_reg <= s3_cmd_reg;
            s4_ok_reg  <= s3_ok_reg;
            s4_r_reg   <= s3_r_reg;
            s4_h_reg   <= h_prod[todc_pkg::RECIP_HOUR_SHIFT +: 5];
        end
        if (adv[5])
        begin
            s5_cmd_reg <= s4_cmd_reg;
            s5_ok_reg  <= s4_ok_reg;
            s5_h_reg   <= s4_h_reg;
            s5_rem_reg <= rem_full[11:0];
        end
        if (adv[6])
        begin
            s6_cmd_reg <= s5_cmd_reg;
            s6_ok_reg  <= s5_ok_reg;
            s6_h_reg   <= s5_h_reg;
            s6_rem_reg <= s5_rem_reg;
            s6_m_reg   <= m_prod[todc_pkg::RECIP_MIN_SHIFT +: 6];
        end
        if (adv[7])
        begin
            s7_cmd_reg  <= s6_cmd_reg;
            s7_ok_reg   <= s6_ok_reg;
            s7_op_reg.h <= s6_h_reg;
            s7_op_reg.m <= s6_m_reg;
            s7_op_reg.s <= s_full[5:0];
        end
        if (adv[8])
        begin
            s8_show_reg <= s8_show_next;
            s8_dif_reg  <= s8_dif_next;
            s8_bad_reg  <= s8_bad_next;
        end
        if (adv[9])
        begin
            s9_show_reg <= s8_show_reg;
            s9_dif_reg  <= dif_sec;
            s9_bad_reg  <= s8_bad_reg;
        end
    end

`ifndef SYNTH
    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_time_reg.h <= 5'(todc_pkg::MAX_HOUR))
        && (cur_time_reg.m <= 6'(todc_pkg::MAX_MIN_SEC))
        && (cur_time_reg.s <= 6'(todc_pkg::MAX_MIN_SEC)))
        else $error("stored time out of range");

    a_operand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST-1] |-> (s7_op_reg.h <= 5'(todc_pkg::MAX_HOUR))
                        && (s7_op_reg.m <= 6'(todc_pkg::MAX_MIN_SEC))
                        && (s7_op_reg.s <= 6'(todc_pkg::MAX_MIN_SEC)))
        else $error("reduced operand out of range");

    a_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv[ST] && vld_reg[ST-1]) |=> $stable(cur_time_reg))
        else $error("stored time changed without a beat");

    a_bad_no_diff: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[33:17] == 17'd0))
        else $error("error beat carries a difference");

    a_diff_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:17] < 17'd86400))
        else $error("difference out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 24-hour time-of-day clock core. Commands go in
// on the s_ stream under random burst gaps. Results leave the m_ stream under
// random receiver stalls. A local predictor tracks the stored time and checks
// every result beat, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam longint DAY_SECONDS =
        longint'(todc_pkg::HOURS_PER_DAY) * todc_pkg::HOUR_SECONDS;

    typedef struct packed {
        todc_pkg::hms_t t;
        logic [16:0]    diff;
        logic           bad;
    } clock_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // hours_in, minutes_in, seconds_in, offset_seconds
    logic [2:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // hours_out, minutes_out, seconds_out, difference, zeros
    logic        m_tuser;   // invalid_time

    todc_pkg::hms_t clock_now;
    clock_result_t  expected_times[$];
    clock_result_t  want;
    clock_result_t  got;
    int unsigned    mismatch_count;
    int unsigned    burst_left;
    int unsigned    gap_max;
    int unsigned    stall_max;
    int unsigned    ready_run;

    time_of_day_clock_arith_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** time_of_day_clock_arith_core: FAILED **");
        $finish;
    end

    function automatic longint wrap_day(input longint t);
        longint r;
        r = t % DAY_SECONDS;
        if (r < 0)
            r += DAY_SECONDS;
        return r;
    endfunction

    function automatic todc_pkg::hms_t split_day(input longint t);
        todc_pkg::hms_t r;
        r.h = 5'(t / todc_pkg::HOUR_SECONDS);
        r.m = 6'((t % todc_pkg::HOUR_SECONDS) / todc_pkg::MIN_SEC_RADIX);
        r.s = 6'(t % todc_pkg::MIN_SEC_RADIX);
        return r;
    endfunction

    function automatic clock_result_t predict_clock(input todc_pkg::cmd_t cmd,
                                                    input logic signed [15:0] h,
                                                    input logic signed [15:0] m,
                                                    input logic signed [15:0] s,
                                                    input logic signed [31:0] off);
        longint        opnd;
        longint        now;
        longint        d;
        clock_result_t r;
        r    = '0;
        opnd = longint'(h) * todc_pkg::HOUR_SECONDS
             + longint'(m) * todc_pkg::MIN_SEC_RADIX + longint'(s);
        now  = longint'(clock_now.h) * todc_pkg::HOUR_SECONDS
             + longint'(clock_now.m) * todc_pkg::MIN_SEC_RADIX + longint'(clock_now.s);
        r.t  = clock_now;
        case (cmd)
            todc_pkg::CMD_SET_CHECKED:
            begin
                if (h >= 0 && h <= todc_pkg::MAX_HOUR &&
                    m >= 0 && m <= todc_pkg::MAX_MIN_SEC &&
                    s >= 0 && s <= todc_pkg::MAX_MIN_SEC)
                    clock_now = '{h: 5'(h), m: 6'(m), s: 6'(s)};
                else
                    r.bad = 1'b1;
            end
            todc_pkg::CMD_SET_NORM: clock_now = split_day(wrap_day(opnd));
            todc_pkg::CMD_INC:      clock_now = split_day(wrap_day(now + 1));
            todc_pkg::CMD_DEC:      clock_now = split_day(wrap_day(now - 1));
            todc_pkg::CMD_ADD:      clock_now = split_day(wrap_day(now + longint'(off)));
            todc_pkg::CMD_SUB:      clock_now = split_day(wrap_day(now - longint'(off)));
            todc_pkg::CMD_NEGATE:   ;
            default:
            begin
                d = now - wrap_day(opnd);
                if (d < 0)
                    d = -d;
                r.diff = 17'(d);
            end
        endcase
        if (cmd == todc_pkg::CMD_NEGATE)
            r.t = split_day(wrap_day(-now));
        else
            r.t = clock_now;
        return r;
    endfunction

    // receiver: alternate ready runs and stall runs
    initial
    begin
        m_tready  = 1'b0;
        ready_run = 0;
        forever
        begin
            @(negedge clk);
            if (stall_max == 0)
            begin
                ready_run = 0;
                m_tready <= 1'b1;
            end
            else if (ready_run == 0)
            begin
                if (m_tready)
                begin
                    ready_run = $urandom_range(1, stall_max);
                    m_tready <= 1'b0;
                end
                else
                begin
                    ready_run = $urandom_range(1, 8);
                    m_tready <= 1'b1;
                end
            end
            else
                ready_run--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{t: '{h: m_tdata[4:0], m: m_tdata[10:5], s: m_tdata[16:11]},
                    diff: m_tdata[33:17], bad: m_tuser};
            if (expected_times.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat %0d:%0d:%0d diff %0d bad %0d",
                             $time, got.t.h, got.t.m, got.t.s, got.diff, got.bad);
            end
            else
            begin
                want = expected_times.pop_front();
                if (got.t.h !== want.t.h || got.t.m !== want.t.m || got.t.s !== want.t.s ||
                    got.diff !== want.diff || got.bad !== want.bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp %0d:%0d:%0d diff %0d bad %0d,",
                                  " got %0d:%0d:%0d diff %0d bad %0d"},
                                 $time, want.t.h, want.t.m, want.t.s, want.diff, want.bad,
                                 got.t.h, got.t.m, got.t.s, got.diff, got.bad);
                end
            end
        end
    end

    task automatic send_cmd(input todc_pkg::cmd_t cmd, input logic [15:0] h,
                            input logic [15:0] m, input logic [15:0] s,
                            input logic [31:0] off);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0)
                gap = $urandom_range(0, gap_max);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {off, s, m, h};
        s_tuser  <= cmd;
        burst_left--;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_times.push_back(predict_clock(cmd, h, m, s, off));
    endtask

    task automatic idle_bus();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        idle_bus();
        while (expected_times.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [15:0] h;
        logic [15:0] m;
        logic [15:0] s;
        logic [31:0] off;
        pick = $urandom_range(0, 99);
        h    = 16'($urandom);
        m    = 16'($urandom);
        s    = 16'($urandom);
        off  = $urandom;
        if ($urandom_range(0, 1) == 1)
        begin
            h = 16'(int'($urandom_range(0, 96)) - 48);
            m = 16'(int'($urandom_range(0, 300)) - 150);
            s = 16'(int'($urandom_range(0, 400)) - 200);
        end
        if ($urandom_range(0, 1) == 1)
            off = 32'(int'($urandom_range(0, 400000)) - 200000);
        if (pick < 20)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                h = 16'($urandom_range(0, todc_pkg::MAX_HOUR));
                m = 16'($urandom_range(0, todc_pkg::MAX_MIN_SEC));
                s = 16'($urandom_range(0, todc_pkg::MAX_MIN_SEC));
            end
            send_cmd(todc_pkg::CMD_SET_CHECKED, h, m, s, off);
        end
        else if (pick < 32) send_cmd(todc_pkg::CMD_SET_NORM, h, m, s, off);
        else if (pick < 44) send_cmd(todc_pkg::CMD_INC, h, m, s, off);
        else if (pick < 56) send_cmd(todc_pkg::CMD_DEC, h, m, s, off);
        else if (pick < 68) send_cmd(todc_pkg::CMD_ADD, h, m, s, off);
        else if (pick < 80) send_cmd(todc_pkg::CMD_SUB, h, m, s, off);
        else if (pick < 88) send_cmd(todc_pkg::CMD_NEGATE, h, m, s, off);
        else                send_cmd(todc_pkg::CMD_DIFF, h, m, s, off);
    endtask

    task automatic test_directed();
        gap_max   = 3;
        stall_max = 4;
        send_cmd(todc_pkg::CMD_NEGATE,      16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd23,   16'd59,   16'd59,   32'd0);
        send_cmd(todc_pkg::CMD_INC,         16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_DEC,         16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd24,   16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'hFFFF, 16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'd60,   16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'hFFFF, 16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'd0,    16'd60,   32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'd0,    16'hFFFF, 32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_DEC,         16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_DIFF,        16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd12,   16'd34,   16'd56,   32'd0);
        send_cmd(todc_pkg::CMD_NEGATE,      16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_DIFF,        16'h7FFF, 16'h8000, 16'h7FFF, 32'd0);
        send_cmd(todc_pkg::CMD_SET_NORM,    16'h8000, 16'h8000, 16'h8000, 32'd0);
        send_cmd(todc_pkg::CMD_SET_NORM,    16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd0);
        send_cmd(todc_pkg::CMD_ADD,         16'd0,    16'd0,    16'd0,    32'h7FFF_FFFF);
        send_cmd(todc_pkg::CMD_SUB,         16'd0,    16'd0,    16'd0,    32'h8000_0000);
        send_cmd(todc_pkg::CMD_ADD,         16'd0,    16'd0,    16'd0,    32'h8000_0000);
        send_cmd(todc_pkg::CMD_SUB,         16'd0,    16'd0,    16'd0,    32'h7FFF_FFFF);
        send_cmd(todc_pkg::CMD_SET_CHECKED, 16'd0,    16'd0,    16'd0,    32'd0);
        send_cmd(todc_pkg::CMD_DIFF,        16'd23,   16'd59,   16'd59,   32'd0);
        send_cmd(todc_pkg::CMD_SUB,         16'd0,    16'd0,    16'd0,    32'hFFFF_FFFF);
    endtask

    task automatic test_random_bursts(input int unsigned count);
        gap_max   = 6;
        stall_max = 6;
        repeat (count) send_random();
    endtask

    task automatic test_back_to_back(input int unsigned count);
        gap_max   = 0;
        stall_max = 0;
        repeat (count) send_random();
    endtask

    task automatic test_heavy_stall(input int unsigned count);
        gap_max   = 0;
        stall_max = 30;
        repeat (count) send_random();
    endtask

    task automatic test_drain_pause(input int unsigned batches);
        gap_max   = 4;
        stall_max = 8;
        repeat (batches)
        begin
            repeat ($urandom_range(5, 25)) send_random();
            drain_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = todc_pkg::CMD_SET_CHECKED;
        clock_now      = '0;
        mismatch_count = 0;
        burst_left     = 0;
        gap_max        = 0;
        stall_max      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_bursts(250);
        test_back_to_back(120);
        test_drain_pause(6);
        test_heavy_stall(120);

        drain_results();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && expected_times.size() == 0)
            $display("** time_of_day_clock_arith_core: PASSED **");
        else
            $display("** time_of_day_clock_arith_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/todc_pkg.sv
rtl/core/time_of_day_clock_arith_core.sv
tb/tb.sv
